/* rtl/core/cdif_pkg.sv */
package cdif_pkg;

    localparam int FIFO_DEPTH_DEF = 256;
    localparam int CHAR_W         = 32;
    localparam int COUNT_W        = 9;
    localparam int ASCII_W        = 7;
    localparam int CODE_W         = 8;
    localparam logic [CHAR_W-1:0] CODE_ARROW = 32'h0000_F703;

    typedef enum logic [2:0] {
        OP_CHAR    = 3'd0,
        OP_COMPOSE = 3'd1,
        OP_CANCEL  = 3'd2,
        OP_POP     = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    // compose unit -> FIFO control
    typedef struct packed {
        logic              pass;     // normal-mode character, queue as is
        logic              done;     // compose finished, queue code + arrow
        logic [CODE_W-1:0] code;
        logic              pending;  // compose active with collected chars, after this beat
    } t_cmp_res;

    function automatic logic is_digit(input logic [ASCII_W-1:0] c);
        return (c >= 7'h30) && (c <= 7'h39);
    endfunction

    // digraph table; for duplicate keys the earlier entry is kept
    function automatic logic [CODE_W-1:0] digraph_code(input logic [ASCII_W-1:0] a,
                                                      input logic [ASCII_W-1:0] b);
        logic [15:0] key;
        logic [CODE_W-1:0] code;
        key = {1'b0, a, 1'b0, b};
        case (key)
            "hh", "--": code = 8'd128;
            "vv", "||": code = 8'd129;
            "dr", "ul": code = 8'd130;
            "dl", "ur": code = 8'd131;
            "ll":       code = 8'd132;
            "lr":       code = 8'd133;
            "vr", "lt": code = 8'd134;
            "vl", "rt": code = 8'd135;
            "hd", "tt": code = 8'd136;
            "hu", "bt": code = 8'd137;
            "vh", "++": code = 8'd138;
            "HH", "==": code = 8'd139;
            "VV":       code = 8'd140;
            "DR":       code = 8'd141;
            "DL":       code = 8'd142;
            "UR":       code = 8'd143;
            "UL":       code = 8'd144;
            "dh", "d-": code = 8'd150;
            "dv", "d|": code = 8'd151;
            "DD":       code = 8'd154;
            "Dd":       code = 8'd157;
            "Uu":       code = 8'd160;
            "UU":       code = 8'd163;
            "ub":       code = 8'd179;
            "lb":       code = 8'd180;
            "fb", "##": code = 8'd181;
            "lh":       code = 8'd182;
            "rh":       code = 8'd183;
            "s1", "..": code = 8'd184;
            "s2", "::": code = 8'd185;
            "s3", "%%": code = 8'd186;
            "sq", "[]": code = 8'd200;
            "ci", "()": code = 8'd210;
            "sm", ":)": code = 8'd213;
            "sp":       code = 8'd218;
            "cl":       code = 8'd219;
            "he", "<3": code = 8'd220;
            "di":       code = 8'd221;
            "mu", "m1": code = 8'd222;
            "mm", "m2": code = 8'd223;
            "de", "DG": code = 8'd240;
            "+-", "pm": code = 8'd241;
            "12", "hf": code = 8'd244;
            "14":       code = 8'd252;
            "34":       code = 8'd253;
            default:    code = 8'd0;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/cdif_ram.sv */
module cdif_ram
    import cdif_pkg::*;
#(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cdif_compose.sv */
module cdif_compose
    import cdif_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [2:0]        i_operation,
    input  logic [CHAR_W-1:0] i_character,
    output t_cmp_res          o_res
);

    logic               r_active, n_active;
    logic [1:0]         r_len, n_len;
    logic [ASCII_W-1:0] r_c0, n_c0;
    logic [ASCII_W-1:0] r_c1, n_c1;

    logic [ASCII_W-1:0] ch7;
    logic               printable;
    logic [9:0]         dec;
    logic [CODE_W-1:0]  rom_code;
    t_cmp_res           res;

    assign ch7       = i_character[ASCII_W-1:0];
    assign printable = (i_character >= 32'd32) && (i_character < 32'd127);
    assign dec       = 10'(r_c0[3:0]) * 10'd100 + 10'(r_c1[3:0]) * 10'd10 + 10'(ch7[3:0]);
    assign rom_code  = digraph_code(r_c0, ch7);

    always_comb begin
        n_active = r_active;
        n_len    = r_len;
        n_c0     = r_c0;
        n_c1     = r_c1;
        res      = '0;
        case (t_op'(i_operation))
            OP_CHAR: begin
                if (!r_active) begin
                    res.pass = 1'b1;
                end else if (!printable) begin
                    n_active = 1'b0;
                    n_len    = 2'd0;
                end else begin
                    case (r_len)
                        2'd0: begin
                            n_c0  = ch7;
                            n_len = 2'd1;
                        end
                        2'd1: begin
                            n_c1  = ch7;
                            n_len = 2'd2;
                            // digraph lookup only when the first char is not a digit
                            if (!is_digit(r_c0) && rom_code != '0) begin
                                res.done = 1'b1;
                                res.code = rom_code;
                                n_active = 1'b0;
                                n_len    = 2'd0;
                            end
                        end
                        2'd2: begin
                            // third char always ends compose
                            if (is_digit(r_c0) && is_digit(r_c1) && is_digit(ch7)
                                && dec >= 10'd128 && dec <= 10'd255) begin
                                res.done = 1'b1;
                                res.code = dec[CODE_W-1:0];
                            end
                            n_active = 1'b0;
                            n_len    = 2'd0;
                        end
                        default: begin
                            n_active = 1'b0;
                            n_len    = 2'd0;
                        end
                    endcase
                end
            end
            OP_COMPOSE: begin
                n_active = 1'b1;
                n_len    = 2'd0;
            end
            OP_CANCEL: begin
                n_active = 1'b0;
                n_len    = 2'd0;
            end
            default: begin
            end
        endcase
        res.pending = n_active && (n_len != 2'd0);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_len    <= 2'd0;
        end else if (i_acc) begin
            r_active <= n_active;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_c0 <= n_c0;
            r_c1 <= n_c1;
        end
    end

endmodule

/* rtl/core/compose_digraph_input_fifo_core.sv */
// Character input FIFO with compose (digraph / decimal) entry.
// Input channel (i_in_valid / o_in_stall): one beat per operation:
//   character, enter compose, cancel compose, pop head, clear FIFO.
// Output channel (o_out_valid / i_out_stall): exactly one result beat per
//   input beat, in order: popped character (0 if none), FIFO fill after the
//   operation, and the compose-pending flag.
// A taken input beat goes through stage 2 and then the output register
//   before its result is presented.
// Throughput: one beat per cycle unless the output stalls. A completed
//   compose whose arrow code fits queues two entries through the single
//   write port of the character RAM; the beat after it stalls meanwhile.
// Character storage is one RAM of FIFO_DEPTH words with a registered read;
//   a pop reads it and the data is joined to the result one stage later.
// Reset (synchronous, active low) empties the FIFO, leaves compose mode
//   and drops any beats in flight. RAM contents are not cleared; they are
//   only read after being written.
// A stall on the output holds the output register; once the internal stage
//   is also occupied, o_in_stall rises combinationally, so nothing is lost.
module compose_digraph_input_fifo_core
    import cdif_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic [CHAR_W-1:0]  i_character,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CHAR_W-1:0]  o_popped_char,
    output logic [COUNT_W-1:0] o_buffer_count,
    output logic               o_compose_pending
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // handshake
    logic acc_in, out_free, s2_free;

    // FIFO control state
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend2, n_pend2;   // arrow code still to be written

    // RAM port
    logic              ram_we, ram_re;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;
    logic              pop_hit;

    t_cmp_res cmp;

    // stage 2: waits for RAM read data
    logic               r_s2_valid;
    logic               r_s2_hit;
    logic [COUNT_W-1:0] r_s2_count;
    logic               r_s2_pend;

    // output register
    logic               r_o_valid;
    logic [CHAR_W-1:0]  r_o_char;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_pend;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free   = !r_o_valid || !i_out_stall;
    assign s2_free    = !r_s2_valid || out_free;
    assign o_in_stall = !s2_free || r_pend2;
    assign acc_in     = i_in_valid && !o_in_stall;

    cdif_compose u_compose (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc_in),
        .i_operation (i_operation),
        .i_character (i_character),
        .o_res       (cmp)
    );

    always_comb begin
        n_rptr    = r_rptr;
        n_wptr    = r_wptr;
        n_count   = r_count;
        n_pend2   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = i_character;
        pop_hit   = 1'b0;
        if (r_pend2) begin
            // second beat of a completed compose; room was checked already
            ram_we    = 1'b1;
            ram_wdata = CODE_ARROW;
            n_wptr    = ptr_inc(r_wptr);
        end else if (acc_in) begin
            case (t_op'(i_operation))
                OP_CHAR: begin
                    if (cmp.pass && r_count < CNT_W'(FIFO_DEPTH)) begin
                        ram_we  = 1'b1;
                        n_wptr  = ptr_inc(r_wptr);
                        n_count = r_count + 1'b1;
                    end else if (cmp.done && r_count < CNT_W'(FIFO_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_wdata = CHAR_W'(cmp.code);
                        n_wptr    = ptr_inc(r_wptr);
                        n_count   = r_count + 1'b1;
                        // count covers the arrow now so the result shows both
                        if (r_count < CNT_W'(FIFO_DEPTH - 1)) begin
                            n_pend2 = 1'b1;
                            n_count = r_count + CNT_W'(2);
                        end
                    end
                end
                OP_POP: begin
                    if (r_count != '0) begin
                        ram_re  = 1'b1;
                        pop_hit = 1'b1;
                        n_rptr  = ptr_inc(r_rptr);
                        n_count = r_count - 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_rptr  = '0;
                    n_wptr  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    cdif_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_count    <= '0;
            r_pend2    <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_rptr  <= n_rptr;
            r_wptr  <= n_wptr;
            r_count <= n_count;
            r_pend2 <= n_pend2;
            if (s2_free) begin
                r_s2_valid <= acc_in;
            end
            if (out_free) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s2_hit   <= pop_hit;
            r_s2_count <= COUNT_W'(n_count);
            r_s2_pend  <= cmp.pending;
        end
        if (out_free && r_s2_valid) begin
            r_o_char  <= r_s2_hit ? ram_rdata : '0;
            r_o_count <= r_s2_count;
            r_o_pend  <= r_s2_pend;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_popped_char     = r_o_char;
    assign o_buffer_count    = r_o_count;
    assign o_compose_pending = r_o_pend;

endmodule

/* tb/tb.sv */
module tb
    import cdif_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int DIRECTED_BEATS = 26;
    localparam int RANDOM_BEATS   = 624;
    localparam int BURST_AT       = 300;     // fill-to-full burst starts here
    localparam int PHASE1_END     = 300;     // sender 20 %, receiver 63 %
    localparam int PHASE2_END     = 520;     // sender 63 %, receiver 20 %, then none
    localparam int HOLD_AT        = 100;     // long receiver hold-off starts here
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;      // leave margin after the last result
    localparam int CYCLE_LIMIT    = 200000;

    localparam int DEPTH = FIFO_DEPTH_DEF;

    // Operation codes the block ignores
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [2:0]        op;
        logic [CHAR_W-1:0] ch;
        bit                drain_first;   // hold this beat until all results are back
    } t_beat;

    typedef struct packed {
        logic [CHAR_W-1:0]  popped;
        logic [COUNT_W-1:0] count;
        logic               pending;
    } t_reply;

    // DUT ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [2:0]         i_operation = '0;
    logic [CHAR_W-1:0]  i_character = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [CHAR_W-1:0]  o_popped_char;
    logic [COUNT_W-1:0] o_buffer_count;
    logic               o_compose_pending;

    t_beat  stimulus_q[$];
    t_reply replies_due[$];

    int beats_sent  = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    int real_beats  = 0;    // beats the block acts on (unused opcodes excluded)

    // Shadow state of the character FIFO and the compose unit
    bit              cmp_active = 1'b0;
    logic [6:0]      cmp_chars [3];
    int              cmp_len = 0;
    logic [CHAR_W-1:0] char_mem [DEPTH];
    int              rd_ptr = 0;
    int              wr_ptr = 0;
    int              fill   = 0;

    // Digraph table {first, second, code}; scanned in order, first hit wins
    logic [23:0] digraph_rom [72] = '{
        {"hh", 8'd128}, {"--", 8'd128}, {"vv", 8'd129}, {"||", 8'd129},
        {"dr", 8'd130}, {"ul", 8'd130}, {"dl", 8'd131}, {"ur", 8'd131},
        {"ur", 8'd132}, {"ll", 8'd132}, {"ul", 8'd133}, {"lr", 8'd133},
        {"vr", 8'd134}, {"lt", 8'd134}, {"vl", 8'd135}, {"rt", 8'd135},
        {"hd", 8'd136}, {"tt", 8'd136}, {"hu", 8'd137}, {"bt", 8'd137},
        {"vh", 8'd138}, {"++", 8'd138}, {"HH", 8'd139}, {"==", 8'd139},
        {"VV", 8'd140}, {"DR", 8'd141}, {"DL", 8'd142}, {"UR", 8'd143},
        {"UL", 8'd144}, {"dh", 8'd150}, {"d-", 8'd150}, {"dv", 8'd151},
        {"d|", 8'd151}, {"DD", 8'd154}, {"Dd", 8'd157}, {"Uu", 8'd160},
        {"UU", 8'd163}, {"ub", 8'd179}, {"lb", 8'd180}, {"fb", 8'd181},
        {"##", 8'd181}, {"lh", 8'd182}, {"rh", 8'd183}, {"s1", 8'd184},
        {"..", 8'd184}, {"s2", 8'd185}, {"::", 8'd185}, {"s3", 8'd186},
        {"%%", 8'd186}, {"sq", 8'd200}, {"[]", 8'd200}, {"ci", 8'd210},
        {"()", 8'd210}, {"sm", 8'd213}, {":)", 8'd213}, {"sp", 8'd218},
        {"cl", 8'd219}, {"he", 8'd220}, {"<3", 8'd220}, {"di", 8'd221},
        {"mu", 8'd222}, {"m1", 8'd222}, {"mm", 8'd223}, {"m2", 8'd223},
        {"de", 8'd240}, {"DG", 8'd240}, {"+-", 8'd241}, {"pm", 8'd241},
        {"12", 8'd244}, {"hf", 8'd244}, {"14", 8'd252}, {"34", 8'd253}
    };

    compose_digraph_input_fifo_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_character       (i_character),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_popped_char     (o_popped_char),
        .o_buffer_count    (o_buffer_count),
        .o_compose_pending (o_compose_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------
    function automatic bit ascii_digit(input logic [6:0] c);
        return (c >= 7'd48) && (c <= 7'd57);
    endfunction

    function automatic logic [7:0] digraph_lookup(input logic [6:0] a, input logic [6:0] b);
        int k;
        for (k = 0; k < 72; k++) begin
            if (digraph_rom[k][23:16] == {1'b0, a} && digraph_rom[k][15:8] == {1'b0, b})
                return digraph_rom[k][7:0];
        end
        return 8'd0;
    endfunction

    // Full store drops the write silently
    task automatic store_push(input logic [CHAR_W-1:0] v);
        if (fill < DEPTH) begin
            char_mem[wr_ptr] = v;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
        end
    endtask

    // Advance the shadow state by one accepted beat and queue its result
    task automatic compute_reply(input logic [2:0] op, input logic [CHAR_W-1:0] ch);
        t_reply r;
        int     code;
        bit     done;
        bit     abort;
        r.popped = '0;
        case (op)
            OP_CHAR: begin
                if (!cmp_active) begin
                    store_push(ch);
                end else if (ch < 32 || ch >= 127 || cmp_len > 2) begin
                    // non-printable (or overlong) kills compose, char discarded
                    cmp_active = 1'b0;
                    cmp_len    = 0;
                end else begin
                    cmp_chars[cmp_len] = ch[6:0];
                    cmp_len++;
                    done  = 1'b0;
                    abort = 1'b0;
                    code  = 0;
                    if (ascii_digit(cmp_chars[0])) begin
                        // decimal entry: needs three digits worth 128..255
                        if (cmp_len == 3 && ascii_digit(cmp_chars[1])
                                && ascii_digit(cmp_chars[2])) begin
                            code = (int'(cmp_chars[0]) - 48) * 100
                                 + (int'(cmp_chars[1]) - 48) * 10
                                 + (int'(cmp_chars[2]) - 48);
                            if (code < 128 || code > 255)
                                abort = 1'b1;
                            else
                                done = 1'b1;
                        end
                    end else if (cmp_len == 2) begin
                        code = int'(digraph_lookup(cmp_chars[0], cmp_chars[1]));
                        done = (code >= 128);
                    end
                    if (done) begin
                        store_push(code);
                        store_push(CODE_ARROW);
                    end
                    if (done || abort || cmp_len >= 3) begin
                        cmp_active = 1'b0;
                        cmp_len    = 0;
                    end
                end
            end
            OP_COMPOSE: begin
                cmp_active = 1'b1;
                cmp_len    = 0;
            end
            OP_CANCEL: begin
                cmp_active = 1'b0;
                cmp_len    = 0;
            end
            OP_POP: begin
                if (fill > 0) begin
                    r.popped = char_mem[rd_ptr];
                    rd_ptr   = (rd_ptr + 1) % DEPTH;
                    fill--;
                end
            end
            OP_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                fill   = 0;
            end
            default: ;
        endcase
        r.count   = fill[COUNT_W-1:0];
        r.pending = cmp_active && (cmp_len > 0);
        replies_due.insert(replies_due.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_beat(input logic [2:0] op, input logic [CHAR_W-1:0] ch,
                            input bit drain = 1'b0);
        t_beat b;
        b.op          = op;
        b.ch          = ch;
        b.drain_first = drain;
        stimulus_q.insert(stimulus_q.size(), b);
        if (op <= OP_CLEAR)
            real_beats++;
    endtask

    // three ASCII digits of v (v < 1000)
    task automatic add_decimal(input int v);
        add_beat(OP_CHAR, 48 + v / 100);
        add_beat(OP_CHAR, 48 + (v / 10) % 10);
        add_beat(OP_CHAR, 48 + v % 10);
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit();
        return 48 + $urandom_range(9);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_nondigit();
        return $urandom_range(1) ? $urandom_range(47, 32) : $urandom_range(126, 58);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the next pending beat once the current one is taken.
    // The shadow model is stepped here, at the edge the beat is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat nxt;
        bit    offer;
        int    idle_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                compute_reply(i_operation, i_character);
                beats_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                idle_pct = (beats_sent < PHASE1_END) ? 20 :
                           (beats_sent < PHASE2_END) ? 63 : 0;
                offer = 1'b0;
                if (stimulus_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    // a drain beat waits until every earlier result is back
                    if (!stimulus_q[0].drain_first || replies_due.size() == 0)
                        offer = 1'b1;
                end
                if (offer) begin
                    nxt = stimulus_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= nxt.op;
                    i_character <= nxt.ch;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random per phase, plus one long hold-off so the
    // block backs up and stalls its input.
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < ((beats_sent < PHASE1_END) ? 63 :
                                (beats_sent < PHASE2_END) ? 20 : 0));
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every taken result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (o_popped_char !== want.popped) begin
                    $error("popped_char: expected %h, got %h", want.popped, o_popped_char);
                    mismatches++;
                end
                if (o_buffer_count !== want.count) begin
                    $error("buffer_count: expected %0d, got %0d", want.count, o_buffer_count);
                    mismatches++;
                end
                if (o_compose_pending !== want.pending) begin
                    $error("compose_pending: expected %b, got %b",
                           want.pending, o_compose_pending);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          r;
        int          n;
        int          k;
        bit          burst_done;
        logic [23:0] ent;
        burst_done = 1'b0;

        // --- directed ---
        add_beat(OP_POP, 32'hFFFF_FFFF);           // pop on empty, payload ignored
        add_beat(OP_CHAR, 32'h0000_0000);
        add_beat(OP_CHAR, 32'hFFFF_FFFF);
        add_beat(OP_UNUSED_HI, 32'hFFFF_FFFF);     // ignored opcode
        add_beat(OP_CANCEL, 32'h0);                // cancel while not composing
        add_beat(OP_POP, 32'h0);
        add_beat(OP_POP, 32'h0);
        add_beat(OP_COMPOSE, 32'h0);               // duplicate key: first entry wins
        add_beat(OP_CHAR, CHAR_W'("u"));
        add_beat(OP_CHAR, CHAR_W'("r"));
        add_beat(OP_COMPOSE, 32'h0);               // decimal just above range
        add_decimal(256);
        add_beat(OP_COMPOSE, 32'h0);               // unknown digraph, third char cancels
        add_beat(OP_CHAR, CHAR_W'("x"));
        add_beat(OP_CHAR, CHAR_W'("y"));
        add_beat(OP_CHAR, CHAR_W'("z"));
        add_beat(OP_COMPOSE, 32'h0);               // non-printable cancels
        add_beat(OP_CHAR, 32'h7F);
        add_beat(OP_COMPOSE, 32'h0);               // re-enter drops the collected char
        add_beat(OP_CHAR, CHAR_W'("h"));
        add_beat(OP_COMPOSE, 32'h0);
        add_beat(OP_CHAR, CHAR_W'("h"));
        add_beat(OP_CHAR, CHAR_W'("h"));
        add_beat(OP_CLEAR, 32'hFFFF_FFFF);

        // --- random; the first one waits for the directed results ---
        add_beat(OP_POP, $urandom, 1'b1);
        while (real_beats < DIRECTED_BEATS + RANDOM_BEATS) begin
            if (!burst_done && real_beats >= BURST_AT) begin
                // fill to the brim; the compose arrow and later pushes are dropped
                burst_done = 1'b1;
                add_beat(OP_CLEAR, $urandom);
                for (k = 0; k < DEPTH - 1; k++)
                    add_beat(OP_CHAR, $urandom);
                add_beat(OP_COMPOSE, $urandom);
                add_beat(OP_CHAR, CHAR_W'("d"));
                add_beat(OP_CHAR, CHAR_W'("r"));
                add_beat(OP_CHAR, $urandom);
                add_beat(OP_COMPOSE, $urandom);
                add_decimal(200);
                for (k = 0; k < 3; k++)
                    add_beat(OP_POP, $urandom);
                add_beat(OP_CANCEL, $urandom, 1'b1);
            end
            r = $urandom_range(104);
            if (r < 25) begin
                // well-formed digraph
                ent = digraph_rom[$urandom_range(71)];
                add_beat(OP_COMPOSE, $urandom);
                add_beat(OP_CHAR, CHAR_W'(ent[23:16]));
                add_beat(OP_CHAR, CHAR_W'(ent[15:8]));
            end else if (r < 37) begin
                add_beat(OP_COMPOSE, $urandom);
                add_decimal($urandom_range(255, 128));
            end else if (r < 52) begin
                add_beat(OP_COMPOSE, $urandom);
                case ($urandom_range(6))
                    0: add_decimal($urandom_range(1) ? $urandom_range(127)
                                                    : $urandom_range(999, 256));
                    1: begin
                        add_beat(OP_CHAR, rand_digit());
                        if ($urandom_range(1)) begin
                            add_beat(OP_CHAR, rand_nondigit());
                            add_beat(OP_CHAR, rand_digit());
                        end else begin
                            add_beat(OP_CHAR, rand_digit());
                            add_beat(OP_CHAR, rand_nondigit());
                        end
                    end
                    2: begin
                        add_beat(OP_CHAR, rand_nondigit());
                        add_beat(OP_CHAR, $urandom_range(126, 32));
                        add_beat(OP_CHAR, $urandom_range(126, 32));
                    end
                    3: begin
                        n = $urandom_range(2);
                        for (k = 0; k < n; k++)
                            add_beat(OP_CHAR, $urandom_range(126, 32));
                        case ($urandom_range(2))
                            0:       add_beat(OP_CHAR, $urandom_range(31));
                            1:       add_beat(OP_CHAR, $urandom_range(255, 127));
                            default: add_beat(OP_CHAR, $urandom | 32'h8000_0000);
                        endcase
                    end
                    4: begin
                        ent = digraph_rom[$urandom_range(71)];
                        add_beat(OP_CHAR, $urandom_range(126, 32));
                        add_beat(OP_COMPOSE, $urandom);
                        add_beat(OP_CHAR, CHAR_W'(ent[23:16]));
                        add_beat(OP_CHAR, CHAR_W'(ent[15:8]));
                    end
                    5: begin
                        add_beat(OP_CHAR, $urandom_range(126, 32));
                        add_beat(OP_CANCEL, $urandom);
                    end
                    default: begin
                        // FIFO ops in the middle of a digraph leave compose alone
                        ent = digraph_rom[$urandom_range(71)];
                        add_beat(OP_CHAR, CHAR_W'(ent[23:16]));
                        add_beat($urandom_range(1) ? OP_POP : OP_CLEAR, $urandom);
                        add_beat(OP_CHAR, CHAR_W'(ent[15:8]));
                    end
                endcase
            end else if (r < 62) begin
                add_beat(OP_CHAR, $urandom);
            end else if (r < 97) begin
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++)
                    add_beat(OP_POP, $urandom);
            end else if (r < 100) begin
                add_beat(OP_CANCEL, $urandom);
            end else if (r < 102) begin
                add_beat(OP_CLEAR, $urandom);
            end else begin
                add_beat(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), $urandom);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stimulus_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
